[sv/dht_pkg.sv]
// Shared types and constants for the double hashing table unit.
// No dependencies; every other file takes names from here by scope.
`default_nettype none

package dht_pkg;

    // Field widths fixed by the request and result formats.
    localparam int REQ_W    = 2;
    localparam int KEY_W    = 31;
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 2;
    localparam int SIDX_W   = 10;
    localparam int TS_W     = 11;
    localparam int PC_W     = TS_W + 1;
    localparam int CNT_W    = 11;
    localparam int TS_MAX   = (2 ** TS_W) - 1;

    // Remainder unit: dividend word, bits retired per cycle, pass lengths.
    localparam int DIV_W       = 32;
    localparam int DIG_BITS    = 4;
    localparam int DIG_CNT_W   = 4;
    localparam int STEP_W      = 8;
    localparam int KEY_DIGITS  = DIV_W / DIG_BITS;
    localparam int STEP_DIGITS = STEP_W / DIG_BITS;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FIND   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    // One slot of the table.
    typedef struct packed {
        logic             used;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

endpackage

`default_nettype wire

[sv/dht_in_if.sv]
// Request channel: valid/ready handshake with the request payload.
// Depends on dht_pkg for field widths.
`default_nettype none

interface dht_in_if;
    logic                        valid;
    logic                        ready;
    logic [dht_pkg::REQ_W-1:0]   req_type;
    logic [dht_pkg::KEY_W-1:0]   key;
    logic [dht_pkg::VAL_W-1:0]   value;

    modport source (output valid, output req_type, output key, output value, input ready);
    modport sink   (input valid, input req_type, input key, input value, output ready);
endinterface

`default_nettype wire

[sv/dht_out_if.sv]
// Result channel: valid/ready handshake with the result payload.
// Depends on dht_pkg for field widths.
`default_nettype none

interface dht_out_if;
    logic                        valid;
    logic                        ready;
    logic [dht_pkg::STAT_W-1:0]  status;
    logic [dht_pkg::VAL_W-1:0]   found_value;
    logic [dht_pkg::SIDX_W-1:0]  slot_index;
    logic [dht_pkg::TS_W-1:0]    probe_count;
    logic [dht_pkg::CNT_W-1:0]   element_count;

    modport source (output valid, output status, output found_value, output slot_index,
                    output probe_count, output element_count, input ready);
    modport sink   (input valid, input status, input found_value, input slot_index,
                    input probe_count, input element_count, output ready);
endinterface

`default_nettype wire

[sv/dht_mod.sv]
// Multi-cycle remainder unit: dividend mod a run-time divisor and mod the step prime.
// Retires four dividend bits per cycle; depends on dht_pkg.
`default_nettype none

module dht_mod #(
    parameter int STEP_PRIME = 11
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [dht_pkg::DIV_W-1:0]      dividend,
    input  wire logic [dht_pkg::DIG_CNT_W-1:0]  digits,
    input  wire logic [dht_pkg::TS_W-1:0]       divisor,
    output logic                                done,
    output logic [dht_pkg::TS_W-1:0]            rem,
    output logic [dht_pkg::STEP_W-1:0]          rem_p
);

    localparam logic [dht_pkg::STEP_W:0] PRIME = (dht_pkg::STEP_W + 1)'(STEP_PRIME);

    logic                            busy_reg;
    logic                            done_reg;
    logic [dht_pkg::DIG_CNT_W-1:0]   cnt_reg;
    logic [dht_pkg::DIV_W-1:0]       dv_reg;
    logic [dht_pkg::TS_W-1:0]        r_reg;
    logic [dht_pkg::TS_W-1:0]        r_next;
    logic [dht_pkg::STEP_W-1:0]      rp_reg;
    logic [dht_pkg::STEP_W-1:0]      rp_next;

    // Four restoring steps per cycle on both remainders.
    always_comb
    begin
        logic [dht_pkg::TS_W:0]   rx;
        logic [dht_pkg::STEP_W:0] rpx;
        r_next  = r_reg;
        rp_next = rp_reg;
        for (int k = 0; k < dht_pkg::DIG_BITS; k++)
        begin
            rx = {r_next, dv_reg[dht_pkg::DIV_W-1-k]};
            if (rx >= {1'b0, divisor})
            begin
                rx = rx - {1'b0, divisor};
            end
            r_next = rx[dht_pkg::TS_W-1:0];
            rpx = {rp_next, dv_reg[dht_pkg::DIV_W-1-k]};
            if (rpx >= PRIME)
            begin
                rpx = rpx - PRIME;
            end
            rp_next = rpx[dht_pkg::STEP_W-1:0];
        end
    end

    // Control of one pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= digits;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == dht_pkg::DIG_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath of one pass.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dv_reg <= dividend;
            r_reg  <= '0;
            rp_reg <= '0;
        end
        else if (busy_reg)
        begin
            dv_reg <= dv_reg << dht_pkg::DIG_BITS;
            r_reg  <= r_next;
            rp_reg <= rp_next;
        end
    end

    assign done  = done_reg;
    assign rem   = r_reg;
    assign rem_p = rp_reg;

endmodule

`default_nettype wire

[sv/dht_store.sv]
// Slot memory: one write port and one read port with registered read data.
// Depends on dht_pkg for the entry layout.
`default_nettype none

module dht_store #(
    parameter int CAPACITY = 1024
) (
    input  wire logic                           clk,
    input  wire logic                           wr_en,
    input  wire logic [$clog2(CAPACITY)-1:0]    wr_addr,
    input  wire dht_pkg::entry_t                wr_data,
    input  wire logic                           rd_en,
    input  wire logic [$clog2(CAPACITY)-1:0]    rd_addr,
    output dht_pkg::entry_t                     rd_data
);

    dht_pkg::entry_t mem [CAPACITY];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[sv/double_hash_table_unit.sv]
// Double hashing table unit, one request at a time. A request passes through the key
// remainder, the step remainder, one read issue, the probe of the home slot and of P
// further slots (P from 0 to the effective table size + 1), and one output load. The next
// request is taken only after the result has been loaded into the output register. An
// unknown request type goes straight to the output load. After reset a clearing pass
// empties every slot and holds off requests; table_size resets to 1024.
`default_nettype none

module double_hash_table_unit #(
    parameter int CAPACITY   = 1024,
    parameter int STEP_PRIME = 11
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [dht_pkg::TS_W-1:0]  cfg_wdata,
    dht_in_if.sink                         in_ch,
    dht_out_if.source                      out_ch
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam logic [dht_pkg::TS_W-1:0] CAP_N =
        dht_pkg::TS_W'((CAPACITY > dht_pkg::TS_MAX) ? dht_pkg::TS_MAX : CAPACITY);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CAPACITY - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIVK  = 3'd2;
    localparam logic [2:0] S_DIVS  = 3'd3;
    localparam logic [2:0] S_ISSUE = 3'd4;
    localparam logic [2:0] S_PROBE = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]                     state_reg;
    logic [2:0]                     state_next;
    logic [dht_pkg::TS_W-1:0]       size_reg;
    logic [dht_pkg::TS_W-1:0]       n_eff;
    logic [dht_pkg::TS_W-1:0]       n_reg;
    logic [ADDR_W-1:0]              clr_reg;
    logic [dht_pkg::CNT_W-1:0]      cnt_reg;
    logic [dht_pkg::CNT_W-1:0]      cnt_next;

    logic [dht_pkg::REQ_W-1:0]      req_reg;
    logic [dht_pkg::KEY_W-1:0]      key_reg;
    logic [dht_pkg::VAL_W-1:0]      val_reg;
    logic [dht_pkg::TS_W-1:0]       home_reg;
    logic [dht_pkg::TS_W-1:0]       smod_reg;
    logic [dht_pkg::TS_W-1:0]       iss_reg;
    logic [dht_pkg::PC_W-1:0]       pc_reg;

    logic [dht_pkg::STAT_W-1:0]     res_status_reg;
    logic [dht_pkg::VAL_W-1:0]      res_fval_reg;
    logic [dht_pkg::TS_W-1:0]       res_sidx_reg;
    logic [dht_pkg::PC_W-1:0]       res_pc_reg;

    logic                           out_valid_reg;
    logic [dht_pkg::STAT_W-1:0]     out_status_reg;
    logic [dht_pkg::VAL_W-1:0]      out_fval_reg;
    logic [dht_pkg::SIDX_W-1:0]     out_sidx_reg;
    logic [dht_pkg::TS_W-1:0]       out_pc_reg;
    logic [dht_pkg::CNT_W-1:0]      out_cnt_reg;

    logic                           in_fire;
    logic                           known_req;
    logic                           div_start;
    logic [dht_pkg::DIV_W-1:0]      div_dividend;
    logic [dht_pkg::DIG_CNT_W-1:0]  div_digits;
    logic                           div_done;
    logic [dht_pkg::TS_W-1:0]       div_rem;
    logic [dht_pkg::STEP_W-1:0]     div_rem_p;
    logic [dht_pkg::STEP_W-1:0]     step_val;

    logic                           wr_en;
    logic [ADDR_W-1:0]              wr_addr;
    dht_pkg::entry_t                wr_data;
    logic                           rd_en;
    logic [ADDR_W-1:0]              rd_addr;
    dht_pkg::entry_t                rd_data;

    logic [dht_pkg::TS_W:0]         nxt_sum;
    logic [dht_pkg::TS_W-1:0]       nxt_idx;
    logic [dht_pkg::PC_W-1:0]       pc_limit;
    logic                           hit;
    logic                           give_up;
    logic                           out_free;

    // Effective table size: zero acts as one, oversize is clamped to capacity.
    always_comb
    begin
        if (size_reg == '0)
        begin
            n_eff = dht_pkg::TS_W'(1);
        end
        else if (int'(size_reg) > CAPACITY)
        begin
            n_eff = CAP_N;
        end
        else
        begin
            n_eff = size_reg;
        end
    end

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign known_req   = (in_ch.req_type == dht_pkg::REQ_INSERT) ||
                         (in_ch.req_type == dht_pkg::REQ_FIND) ||
                         (in_ch.req_type == dht_pkg::REQ_DELETE);
    assign step_val    = dht_pkg::STEP_W'(STEP_PRIME) - div_rem_p;

    // Remainder unit launch: key pass on accept of a known request, step pass after the key pass.
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = {1'b0, in_ch.key};
        div_digits   = dht_pkg::DIG_CNT_W'(dht_pkg::KEY_DIGITS);
        if (state_reg == S_IDLE && in_fire && known_req)
        begin
            div_start = 1'b1;
        end
        else if (state_reg == S_DIVK && div_done)
        begin
            div_start    = 1'b1;
            div_dividend = {step_val, (dht_pkg::DIV_W - dht_pkg::STEP_W)'(0)};
            div_digits   = dht_pkg::DIG_CNT_W'(dht_pkg::STEP_DIGITS);
        end
    end

    dht_mod #(
        .STEP_PRIME (STEP_PRIME)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .digits   (div_digits),
        .divisor  (n_reg),
        .done     (div_done),
        .rem      (div_rem),
        .rem_p    (div_rem_p)
    );

    // Next probe slot and the probe test on the slot just read.
    assign nxt_sum  = {1'b0, iss_reg} + {1'b0, smod_reg};
    assign nxt_idx  = (nxt_sum >= {1'b0, n_reg}) ? dht_pkg::TS_W'(nxt_sum - {1'b0, n_reg})
                                                : nxt_sum[dht_pkg::TS_W-1:0];
    assign pc_limit = {1'b0, n_reg} + dht_pkg::PC_W'(1);
    assign hit      = (req_reg == dht_pkg::REQ_INSERT) ? !rd_data.used
                                                       : (rd_data.used && rd_data.key == key_reg);
    assign give_up  = (pc_reg == pc_limit);
    assign out_free = !out_valid_reg || out_ch.ready;

    // Memory port control.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = ADDR_W'(iss_reg);
        wr_data = rd_data;
        rd_en   = 1'b0;
        rd_addr = ADDR_W'(nxt_idx);
        cnt_next = cnt_reg;
        if (state_reg == S_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_reg;
            wr_data = '0;
        end
        else if (state_reg == S_ISSUE)
        begin
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(home_reg);
        end
        else if (state_reg == S_PROBE)
        begin
            if (hit)
            begin
                if (req_reg == dht_pkg::REQ_INSERT)
                begin
                    wr_en         = 1'b1;
                    wr_data.used  = 1'b1;
                    wr_data.key   = key_reg;
                    wr_data.value = val_reg;
                    cnt_next      = cnt_reg + 1'b1;
                end
                else if (req_reg == dht_pkg::REQ_DELETE)
                begin
                    wr_en        = 1'b1;
                    wr_data.used = 1'b0;
                    cnt_next     = cnt_reg - 1'b1;
                end
            end
            else if (!give_up)
            begin
                rd_en = 1'b1;
            end
        end
    end

    dht_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = known_req ? S_DIVK : S_DONE;
                end
            end
            S_DIVK:
            begin
                if (div_done)
                begin
                    state_next = S_DIVS;
                end
            end
            S_DIVS:
            begin
                if (div_done)
                begin
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                if (hit || give_up)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            size_reg      <= dht_pkg::TS_W'(1024);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cfg_we)
            begin
                size_reg <= cfg_wdata;
            end
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request and probe datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg        <= in_ch.req_type;
            key_reg        <= in_ch.key;
            val_reg        <= in_ch.value;
            n_reg          <= n_eff;
            res_status_reg <= dht_pkg::ST_MISS;
            res_fval_reg   <= '0;
            res_sidx_reg   <= '0;
            res_pc_reg     <= '0;
        end
        if (state_reg == S_DIVK && div_done)
        begin
            home_reg <= div_rem;
        end
        if (state_reg == S_DIVS && div_done)
        begin
            smod_reg <= div_rem;
        end
        if (state_reg == S_ISSUE)
        begin
            iss_reg <= home_reg;
            pc_reg  <= '0;
        end
        if (state_reg == S_PROBE)
        begin
            if (hit)
            begin
                res_status_reg <= dht_pkg::ST_OK;
                res_sidx_reg   <= iss_reg;
                res_pc_reg     <= pc_reg;
                res_fval_reg   <= (req_reg == dht_pkg::REQ_INSERT) ? '0 : rd_data.value;
            end
            else if (give_up)
            begin
                res_status_reg <= (req_reg == dht_pkg::REQ_INSERT) ? dht_pkg::ST_FULL
                                                                   : dht_pkg::ST_MISS;
                res_pc_reg     <= pc_reg;
            end
            else
            begin
                iss_reg <= nxt_idx;
                pc_reg  <= pc_reg + 1'b1;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && out_free)
        begin
            out_status_reg <= res_status_reg;
            out_fval_reg   <= res_fval_reg;
            out_sidx_reg   <= res_sidx_reg[dht_pkg::SIDX_W-1:0];
            out_pc_reg     <= res_pc_reg[dht_pkg::TS_W-1:0];
            out_cnt_reg    <= cnt_reg;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.status        = out_status_reg;
    assign out_ch.found_value   = out_fval_reg;
    assign out_ch.slot_index    = out_sidx_reg;
    assign out_ch.probe_count   = out_pc_reg;
    assign out_ch.element_count = out_cnt_reg;

endmodule

`default_nettype wire

[sv/dht_checker.sv]
// Port-level checks for the double hashing table unit, and the bind that attaches them.
// Depends on dht_pkg for status codes and on the top level's channel ports.
`default_nettype none

module dht_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_ready,
    input  wire logic                           out_valid,
    input  wire logic                           out_ready,
    input  wire logic [dht_pkg::STAT_W-1:0]     status,
    input  wire logic [dht_pkg::VAL_W-1:0]      found_value,
    input  wire logic [dht_pkg::SIDX_W-1:0]     slot_index,
    input  wire logic [dht_pkg::TS_W-1:0]       probe_count,
    input  wire logic [dht_pkg::CNT_W-1:0]      element_count
);

    // A stalled result beat stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(found_value)
            && $stable(slot_index) && $stable(probe_count) && $stable(element_count))
        else $error("stalled result beat changed");

    // Only the three defined status codes are ever reported.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == dht_pkg::ST_OK || status == dht_pkg::ST_MISS
            || status == dht_pkg::ST_FULL))
        else $error("undefined status code");

    // A miss or a full table reports no value and no slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != dht_pkg::ST_OK |-> found_value == '0 && slot_index == '0)
        else $error("failed request carries a value or slot");

    // The clearing pass holds off requests right after reset.
    assert property (@(posedge clk) $rose(rst_n) |-> !in_ready)
        else $error("request taken before the slot clear finished");

endmodule

bind double_hash_table_unit dht_checker u_dht_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .status        (out_ch.status),
    .found_value   (out_ch.found_value),
    .slot_index    (out_ch.slot_index),
    .probe_count   (out_ch.probe_count),
    .element_count (out_ch.element_count)
);

`default_nettype wire

[bench/double_hash_table_unit_tb.sv]
// Self-checking testbench for double_hash_table_unit: inserts, finds and deletes keys
// across many table sizes and checks every result against an in-bench table model.
// Depends on dht_pkg, dht_in_if, dht_out_if and the unit itself.
`timescale 1ns / 100ps

module double_hash_table_unit_tb;

    localparam int unsigned CAPACITY   = 1024;
    localparam int unsigned STEP_PRIME = 11;
    localparam int          CYCLE_LIMIT = 3000000;
    localparam int          NUM_PHASES  = 12;
    localparam int          HOLD_CYCLES = 400;

    // Request code that the unit does not act on.
    localparam logic [dht_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [dht_pkg::REQ_W-1:0] op;
        logic [dht_pkg::KEY_W-1:0] key;
        logic [dht_pkg::VAL_W-1:0] value;
    } request_t;

    typedef struct packed {
        logic [dht_pkg::STAT_W-1:0] status;
        logic [dht_pkg::VAL_W-1:0]  found_value;
        logic [dht_pkg::SIDX_W-1:0] slot_index;
        logic [dht_pkg::TS_W-1:0]   probe_count;
        logic [dht_pkg::CNT_W-1:0]  element_count;
    } result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [dht_pkg::TS_W-1:0] cfg_wdata;

    dht_in_if  req_if ();
    dht_out_if res_if ();

    double_hash_table_unit #(
        .CAPACITY   (CAPACITY),
        .STEP_PRIME (STEP_PRIME)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (req_if),
        .out_ch    (res_if)
    );

    // Mirror of the slot store, the entry count and the size register.
    logic [dht_pkg::KEY_W-1:0] mirror_key   [CAPACITY];
    logic [dht_pkg::VAL_W-1:0] mirror_value [CAPACITY];
    bit                        mirror_used  [CAPACITY];
    int unsigned               mirror_total = 0;
    int unsigned               mirror_size;

    request_t queued_requests [$];
    result_t  awaited_results [$];

    // Random-phase plan: size register value, count of requests other than the unused code, and key pool size.
    int phase_size  [NUM_PHASES] = '{13, 1, 16, 7, 0, 1024, 97, 2, 2047, 11, 64, 5};
    int phase_items [NUM_PHASES] = '{55, 25, 55, 45, 25, 30, 55, 25, 25, 55, 55, 55};
    int phase_pool  [NUM_PHASES] = '{10, 3, 12, 8, 3, 20, 40, 4, 16, 12, 30, 6};
    logic [dht_pkg::KEY_W-1:0] key_pool [64];

    int  failures = 0;
    int  mismatches = 0;
    int  beats_sent = 0;
    int  beats_checked = 0;
    int  ok_count = 0;
    int  miss_count = 0;
    int  full_count = 0;
    int  cycle_count = 0;
    int  send_gap;
    int  recv_gap;
    int  hold_left;
    bit  quiet_tail;
    bit  hold_requested = 1'b0;
    bit  hold_started = 1'b0;

    // Work out the result of one request and update the mirror as the unit should.
    function automatic result_t predict_table_op(input request_t rq);
        result_t     r;
        int unsigned n;
        int unsigned home;
        int unsigned step;
        int unsigned slot;
        int unsigned probes;
        int unsigned i;
        bit          hit;
        r = '0;
        r.status = dht_pkg::ST_MISS;
        probes = 0;
        hit = 1'b0;
        n = (mirror_size == 0) ? 1 : ((mirror_size > CAPACITY) ? CAPACITY : mirror_size);
        home = rq.key % n;
        step = STEP_PRIME - (rq.key % STEP_PRIME);
        slot = home;
        if (rq.op == dht_pkg::REQ_INSERT)
        begin
            // Walk until an empty slot turns up; no duplicate check.
            if (mirror_used[slot])
            begin
                hit = 1'b1;
                for (i = 1; i <= n + 1; i++)
                begin
                    slot = (home + i * step) % n;
                    probes++;
                    if (!mirror_used[slot])
                    begin
                        hit = 1'b0;
                        break;
                    end
                end
            end
            if (hit)
                r.status = dht_pkg::ST_FULL;
            else
            begin
                mirror_key[slot]   = rq.key;
                mirror_value[slot] = rq.value;
                mirror_used[slot]  = 1'b1;
                mirror_total++;
                r.status     = dht_pkg::ST_OK;
                r.slot_index = slot[dht_pkg::SIDX_W-1:0];
            end
        end
        else if (rq.op == dht_pkg::REQ_FIND || rq.op == dht_pkg::REQ_DELETE)
        begin
            // Walk past empty slots and other keys until the key matches.
            if (mirror_used[slot] && mirror_key[slot] == rq.key)
                hit = 1'b1;
            else
            begin
                for (i = 1; i <= n + 1; i++)
                begin
                    slot = (home + i * step) % n;
                    probes++;
                    if (mirror_used[slot] && mirror_key[slot] == rq.key)
                    begin
                        hit = 1'b1;
                        break;
                    end
                end
            end
            if (hit)
            begin
                r.status      = dht_pkg::ST_OK;
                r.found_value = mirror_value[slot];
                r.slot_index  = slot[dht_pkg::SIDX_W-1:0];
                if (rq.op == dht_pkg::REQ_DELETE)
                begin
                    mirror_used[slot] = 1'b0;
                    mirror_total--;
                end
            end
        end
        r.probe_count   = probes[dht_pkg::TS_W-1:0];
        r.element_count = mirror_total[dht_pkg::CNT_W-1:0];
        return r;
    endfunction

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle counter with a hard limit on the run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still awaited",
                     cycle_count, awaited_results.size());
            $display("status: fail");
            $finish;
        end
    end

    // Request driver: offers queued requests, with random gaps between beats until the quiet tail.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid    <= 1'b0;
            req_if.req_type <= '0;
            req_if.key      <= '0;
            req_if.value    <= '0;
            send_gap = 0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
            begin
                awaited_results.push_back(predict_table_op(
                    '{op: req_if.req_type, key: req_if.key, value: req_if.value}));
                beats_sent++;
            end
            if (!req_if.valid || req_if.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_if.valid <= 1'b0;
                end
                else if (!quiet_tail && $urandom_range(0, 7) == 0)
                begin
                    send_gap = $urandom_range(1, 14) - 1;
                    req_if.valid <= 1'b0;
                end
                else if (queued_requests.size() != 0)
                begin
                    request_t rq;
                    rq = queued_requests.pop_front();
                    req_if.valid    <= 1'b1;
                    req_if.req_type <= rq.op;
                    req_if.key      <= rq.key;
                    req_if.value    <= rq.value;
                end
                else
                    req_if.valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here and seen by the monitor.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (hold_requested && !hold_started)
        begin
            hold_started <= 1'b1;
            hold_left    <= HOLD_CYCLES;
        end
    end

    // Result monitor: checks each beat against the oldest expectation and drives ready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            recv_gap  = 0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                result_t got;
                result_t want;
                got = '{status: res_if.status, found_value: res_if.found_value,
                        slot_index: res_if.slot_index, probe_count: res_if.probe_count,
                        element_count: res_if.element_count};
                beats_checked++;
                case (got.status)
                    dht_pkg::ST_OK:   ok_count++;
                    dht_pkg::ST_FULL: full_count++;
                    default:          miss_count++;
                endcase
                if (awaited_results.size() == 0)
                begin
                    failures++;
                    $display("unexpected result beat: %p", got);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.status !== want.status || got.found_value !== want.found_value ||
                        got.slot_index !== want.slot_index ||
                        got.probe_count !== want.probe_count ||
                        got.element_count !== want.element_count)
                    begin
                        failures++;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch on result %0d: expected %p, got %p",
                                     beats_checked, want, got);
                    end
                end
            end
            // Ready: low through the long hold-off, random stall bursts otherwise until the quiet tail.
            if (hold_left > 0)
                res_if.ready <= 1'b0;
            else if (recv_gap > 0)
            begin
                recv_gap--;
                res_if.ready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                recv_gap = $urandom_range(1, 14) - 1;
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    // Wait until every queued request has been sent and answered.
    task automatic wait_until_drained();
        while (queued_requests.size() != 0 || req_if.valid || awaited_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // Write the size register while the unit is idle.
    task automatic write_table_size(input int unsigned sz);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= sz[dht_pkg::TS_W-1:0];
        mirror_size = sz & dht_pkg::TS_MAX;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic queue_request(input logic [dht_pkg::REQ_W-1:0] op,
                                 input logic [dht_pkg::KEY_W-1:0] key,
                                 input logic [dht_pkg::VAL_W-1:0] value);
        queued_requests.push_back('{op: op, key: key, value: value});
    endtask

    // Stimulus: directed corner cases, then random phases over a range of sizes.
    initial
    begin : stimulus
        int p;
        int k;
        int made;
        int pick;
        request_t rq;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        quiet_tail   = 1'b0;
        mirror_size  = 1024;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset size: extremes, a duplicate, misses, an unused code.
        queue_request(dht_pkg::REQ_INSERT, '0, '0);
        queue_request(dht_pkg::REQ_INSERT, {dht_pkg::KEY_W{1'b1}}, {dht_pkg::VAL_W{1'b1}});
        queue_request(dht_pkg::REQ_INSERT, '0, 32'h1234_5678);
        queue_request(dht_pkg::REQ_FIND, '0, '0);
        queue_request(dht_pkg::REQ_FIND, {dht_pkg::KEY_W{1'b1}}, '0);
        queue_request(dht_pkg::REQ_FIND, 31'd1024, '0);
        queue_request(dht_pkg::REQ_DELETE, '0, '0);
        queue_request(dht_pkg::REQ_FIND, '0, '0);
        queue_request(dht_pkg::REQ_DELETE, 31'd5, '0);
        queue_request(REQ_UNUSED, {dht_pkg::KEY_W{1'b1}}, {dht_pkg::VAL_W{1'b1}});
        queue_request(dht_pkg::REQ_INSERT, 31'd1024, 32'hA5A5_A5A5);
        wait_until_drained();

        // Size zero acts as one bucket: the first insert finds no room, the second goes in
        // after the delete.
        write_table_size(0);
        queue_request(dht_pkg::REQ_FIND, 31'd1024, '0);
        queue_request(dht_pkg::REQ_INSERT, 31'd3, 32'h0F0F_0F0F);
        queue_request(dht_pkg::REQ_DELETE, 31'd1024, '0);
        queue_request(dht_pkg::REQ_INSERT, 31'd3, 32'h0F0F_0F0F);
        queue_request(dht_pkg::REQ_FIND, 31'd77, '0);
        wait_until_drained();

        // Oversized register value acts as the full capacity.
        write_table_size(dht_pkg::TS_MAX);
        queue_request(dht_pkg::REQ_FIND, {dht_pkg::KEY_W{1'b1}}, '0);
        queue_request(dht_pkg::REQ_DELETE, {dht_pkg::KEY_W{1'b1}}, '0);
        queue_request(dht_pkg::REQ_INSERT, 31'h5555_5555, '0);
        queue_request(REQ_UNUSED, '0, '0);
        wait_until_drained();

        // Random phases; each draws most keys from a small pool so that hits are common.
        for (p = 0; p < NUM_PHASES; p++)
        begin
            write_table_size(phase_size[p]);
            for (k = 0; k < phase_pool[p]; k++)
            begin
                if (k % 4 == 0)
                    key_pool[k] = dht_pkg::KEY_W'($urandom_range(0, 50));
                else
                    key_pool[k] = dht_pkg::KEY_W'($urandom());
            end
            if (p == 2)
                hold_requested = 1'b1;
            if (p >= NUM_PHASES - 2)
                quiet_tail = 1'b1;
            made = 0;
            while (made < phase_items[p])
            begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    rq.op = dht_pkg::REQ_INSERT;
                else if (pick < 70)
                    rq.op = dht_pkg::REQ_FIND;
                else if (pick < 95)
                    rq.op = dht_pkg::REQ_DELETE;
                else
                    rq.op = REQ_UNUSED;
                if ($urandom_range(0, 99) < 85)
                    rq.key = key_pool[$urandom_range(0, phase_pool[p] - 1)];
                else
                    rq.key = dht_pkg::KEY_W'($urandom());
                rq.value = $urandom();
                queued_requests.push_back(rq);
                if (rq.op != REQ_UNUSED)
                    made++;
            end
            wait_until_drained();
        end

        // Let any stray beat show up before the verdict.
        repeat (1100) @(negedge clk);
        $display("ran %0d requests under %0d size settings including 0, 1, 1024 and 2047",
                 beats_sent, NUM_PHASES + 3);
        $display("results: %0d done or found, %0d not found, %0d table full, %0d failures",
                 ok_count, miss_count, full_count, failures);
        if (failures == 0 && awaited_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[files.f]
sv/dht_pkg.sv
sv/dht_in_if.sv
sv/dht_out_if.sv
sv/dht_mod.sv
sv/dht_store.sv
sv/double_hash_table_unit.sv
sv/dht_checker.sv
bench/double_hash_table_unit_tb.sv
